### sv/srhc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srhc_pkg
// Shared types and constants for the stereo red hue centroid block.
// ----------------------------------------------------------------------------
package srhc_pkg;

  localparam int LINE_PIXELS = 128;
  localparam int POS_W       = $clog2(LINE_PIXELS);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(LINE_PIXELS - 1);

  localparam int COLOR_W = 8;
  localparam int DIFF_W  = COLOR_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int HUE_D_W = COLOR_W + 3;
  localparam int DMAG_W  = COLOR_W + 1;
  localparam int DD_W    = 2 * DMAG_W;
  localparam int Q_W     = 2 * COLOR_W;

  localparam int WINDOW_W = 11;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 11'd993;
  localparam int WQ_W     = WINDOW_W + Q_W;
  localparam int SCALE_W  = 8;

  localparam int COUNT_W = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam int SUM_W   = 13;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam int ADD_W   = SUM_W + 1;

  localparam int CENT_W  = 15;
  localparam int FRAC_W  = 8;
  localparam int NUM_W   = SUM_W + FRAC_W;
  localparam int STEP_W  = $clog2(NUM_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_W - 1);
  localparam logic [NUM_W-1:0] CENT_MAX = NUM_W'((1 << CENT_W) - 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_HUE_WINDOW = '0;

  typedef struct packed {
    logic [SUM_W-1:0]   left_sum;
    logic [COUNT_W-1:0] left_cnt;
    logic [SUM_W-1:0]   right_sum;
    logic [COUNT_W-1:0] right_cnt;
  } line_tot_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } back_state_t;

endpackage

### sv/srhc_pixel_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srhc_pixel_if
// Input channel: one left and one right RGB pixel per transfer.
// ----------------------------------------------------------------------------
interface srhc_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] left_red;
  logic [7:0] left_green;
  logic [7:0] left_blue;
  logic [7:0] right_red;
  logic [7:0] right_green;
  logic [7:0] right_blue;
  logic       last_pixel;

  modport source (
    output valid, left_red, left_green, left_blue,
           right_red, right_green, right_blue, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, left_red, left_green, left_blue,
           right_red, right_green, right_blue, last_pixel,
    output ready
  );
endinterface

### sv/srhc_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srhc_result_if
// Output channel: one centroid result per line pair.
// ----------------------------------------------------------------------------
interface srhc_result_if;
  logic        valid;
  logic        ready;
  logic        both_found;
  logic [14:0] left_centroid;
  logic [14:0] right_centroid;
  logic [7:0]  left_count;
  logic [7:0]  right_count;

  modport source (
    output valid, both_found, left_centroid, right_centroid,
           left_count, right_count,
    input  ready
  );
  modport sink (
    input  valid, both_found, left_centroid, right_centroid,
           left_count, right_count,
    output ready
  );
endinterface

### sv/srhc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srhc_front
// Hue classification pipeline and per-eye red count and index sum.
// ----------------------------------------------------------------------------
module srhc_front (
  input  logic                        clk,
  input  logic                        rst,
  srhc_pixel_if.sink                  pixel,
  input  logic [srhc_pkg::WINDOW_W-1:0] window,
  output logic                        push,
  output srhc_pkg::line_tot_t         push_data,
  input  logic                        full
);

  logic [srhc_pkg::COLOR_W-1:0] red_c [2];
  logic [srhc_pkg::COLOR_W-1:0] green_c [2];
  logic [srhc_pkg::COLOR_W-1:0] blue_c [2];

  logic signed [srhc_pkg::DIFF_W-1:0]  rg_diff [2];
  logic signed [srhc_pkg::DIFF_W-1:0]  rb_diff [2];
  logic signed [srhc_pkg::DIFF_W-1:0]  gb_diff [2];
  logic signed [srhc_pkg::SQ_W-1:0]    rg_sq [2];
  logic signed [srhc_pkg::SQ_W-1:0]    rb_sq [2];
  logic signed [srhc_pkg::SQ_W-1:0]    gb_sq [2];
  logic [srhc_pkg::SQ_W-1:0]           q_sum [2];
  logic signed [srhc_pkg::HUE_D_W-1:0] d_full [2];

  logic                         pipe_en;
  logic                         s1_valid;
  logic                         s1_last;
  logic                         s1_dpos [2];
  logic [srhc_pkg::DMAG_W-1:0]  s1_dmag [2];
  logic [srhc_pkg::Q_W-1:0]     s1_q [2];
  logic                         s2_valid;
  logic                         s2_last;
  logic                         s2_ok [2];
  logic [srhc_pkg::DD_W-1:0]    s2_dd [2];
  logic [srhc_pkg::WQ_W-1:0]    s2_wq [2];

  logic                         is_red [2];
  logic [srhc_pkg::POS_W-1:0]   pos;
  logic [srhc_pkg::COUNT_W-1:0] cnt [2];
  logic [srhc_pkg::SUM_W-1:0]   sum [2];
  logic [srhc_pkg::COUNT_W-1:0] cnt_next [2];
  logic [srhc_pkg::SUM_W-1:0]   sum_next [2];
  logic [srhc_pkg::ADD_W-1:0]   sum_add [2];

  assign red_c[0]   = pixel.left_red;
  assign green_c[0] = pixel.left_green;
  assign blue_c[0]  = pixel.left_blue;
  assign red_c[1]   = pixel.right_red;
  assign green_c[1] = pixel.right_green;
  assign blue_c[1]  = pixel.right_blue;

  assign pipe_en     = !(s2_valid && s2_last && full);
  assign pixel.ready = pipe_en;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rg_diff[i] = $signed({1'b0, red_c[i]}) - $signed({1'b0, green_c[i]});
      rb_diff[i] = $signed({1'b0, red_c[i]}) - $signed({1'b0, blue_c[i]});
      gb_diff[i] = $signed({1'b0, green_c[i]}) - $signed({1'b0, blue_c[i]});
      rg_sq[i]   = rg_diff[i] * rg_diff[i];
      rb_sq[i]   = rb_diff[i] * rb_diff[i];
      gb_sq[i]   = gb_diff[i] * gb_diff[i];
      q_sum[i]   = $unsigned(rg_sq[i]) + $unsigned(rb_sq[i]) + $unsigned(gb_sq[i]);
      d_full[i]  = $signed({2'b00, red_c[i], 1'b0}) - $signed({3'b000, green_c[i]})
                   - $signed({3'b000, blue_c[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (pipe_en) begin
      s1_valid <= pixel.valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_last <= pixel.last_pixel;
      s2_last <= s1_last;
      for (int i = 0; i < 2; i++) begin
        s1_dpos[i] <= !d_full[i][srhc_pkg::HUE_D_W-1] && (d_full[i] != '0);
        s1_dmag[i] <= d_full[i][srhc_pkg::DMAG_W-1:0];
        s1_q[i]    <= q_sum[i][srhc_pkg::Q_W:1];
        s2_ok[i]   <= s1_dpos[i] && (s1_q[i] != '0);
        s2_dd[i]   <= s1_dmag[i] * s1_dmag[i];
        s2_wq[i]   <= window * s1_q[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      is_red[i] = s2_ok[i] &&
                  ({1'b0, s2_dd[i], {srhc_pkg::SCALE_W{1'b0}}} >= s2_wq[i]);
      sum_add[i] = {1'b0, sum[i]} + srhc_pkg::ADD_W'(pos);
      cnt_next[i] = cnt[i];
      sum_next[i] = sum[i];
      if (is_red[i]) begin
        if (cnt[i] != srhc_pkg::COUNT_MAX) begin
          cnt_next[i] = cnt[i] + 1'b1;
        end
        if (sum_add[i] > srhc_pkg::ADD_W'(srhc_pkg::SUM_MAX)) begin
          sum_next[i] = srhc_pkg::SUM_MAX;
        end else begin
          sum_next[i] = sum_add[i][srhc_pkg::SUM_W-1:0];
        end
      end
    end
  end

  assign push                = pipe_en && s2_valid && s2_last;
  assign push_data.left_sum  = sum_next[0];
  assign push_data.left_cnt  = cnt_next[0];
  assign push_data.right_sum = sum_next[1];
  assign push_data.right_cnt = cnt_next[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      for (int i = 0; i < 2; i++) begin
        cnt[i] <= '0;
        sum[i] <= '0;
      end
    end else if (pipe_en && s2_valid) begin
      if (s2_last) begin
        pos <= '0;
        for (int i = 0; i < 2; i++) begin
          cnt[i] <= '0;
          sum[i] <= '0;
        end
      end else begin
        if (pos != srhc_pkg::POS_MAX) begin
          pos <= pos + 1'b1;
        end
        for (int i = 0; i < 2; i++) begin
          cnt[i] <= cnt_next[i];
          sum[i] <= sum_next[i];
        end
      end
    end
  end

endmodule

### sv/srhc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srhc_queue
// Short queue of line totals between the front and the divider.
// ----------------------------------------------------------------------------
module srhc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  srhc_pkg::line_tot_t push_data,
  output logic                full,
  input  logic                pop,
  output srhc_pkg::line_tot_t pop_data,
  output logic                empty
);

  srhc_pkg::line_tot_t         store [srhc_pkg::QUEUE_DEPTH];
  logic [srhc_pkg::QPTR_W-1:0] wr_ptr;
  logic [srhc_pkg::QPTR_W-1:0] rd_ptr;
  logic [srhc_pkg::QCNT_W-1:0] fill;

  assign full     = (fill == srhc_pkg::QCNT_W'(srhc_pkg::QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### sv/srhc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srhc_back
// Bit-serial centroid divider for both eyes and the result register.
// ----------------------------------------------------------------------------
module srhc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                empty,
  input  srhc_pkg::line_tot_t pop_data,
  output logic                pop,
  srhc_result_if.source       result
);

  srhc_pkg::back_state_t        state;
  logic [srhc_pkg::STEP_W-1:0]  step;
  logic [srhc_pkg::NUM_W-1:0]   num [2];
  logic [srhc_pkg::COUNT_W-1:0] den [2];
  logic [srhc_pkg::COUNT_W-1:0] rem [2];
  logic [srhc_pkg::NUM_W-1:0]   quo [2];
  logic [srhc_pkg::COUNT_W:0]   part [2];
  logic [srhc_pkg::COUNT_W:0]   diff [2];
  logic                         load_out;

  logic                         out_valid;
  logic                         out_both;
  logic [srhc_pkg::CENT_W-1:0]  out_cent [2];
  logic [srhc_pkg::COUNT_W-1:0] out_cnt [2];

  function automatic logic [srhc_pkg::CENT_W-1:0] centroid(
    input logic [srhc_pkg::NUM_W-1:0]   q,
    input logic [srhc_pkg::COUNT_W-1:0] d
  );
    logic [srhc_pkg::CENT_W-1:0] c;
    if (d == '0) begin
      c = '0;
    end else if (q > srhc_pkg::CENT_MAX) begin
      c = srhc_pkg::CENT_MAX[srhc_pkg::CENT_W-1:0];
    end else begin
      c = q[srhc_pkg::CENT_W-1:0];
    end
    return c;
  endfunction

  assign pop      = (state == srhc_pkg::ST_IDLE) && !empty;
  assign load_out = (state == srhc_pkg::ST_DONE) && (!out_valid || result.ready);

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      part[i] = {rem[i], num[i][srhc_pkg::NUM_W-1]};
      diff[i] = part[i] - {1'b0, den[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srhc_pkg::ST_IDLE;
      step  <= '0;
    end else begin
      case (state)
        srhc_pkg::ST_IDLE: begin
          if (!empty) begin
            step  <= '0;
            state <= srhc_pkg::ST_DIV;
          end
        end
        srhc_pkg::ST_DIV: begin
          step <= step + 1'b1;
          if (step == srhc_pkg::STEP_LAST) begin
            state <= srhc_pkg::ST_DONE;
          end
        end
        srhc_pkg::ST_DONE: begin
          if (load_out) begin
            state <= srhc_pkg::ST_IDLE;
          end
        end
        default: state <= srhc_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      num[0] <= {pop_data.left_sum, {srhc_pkg::FRAC_W{1'b0}}};
      num[1] <= {pop_data.right_sum, {srhc_pkg::FRAC_W{1'b0}}};
      den[0] <= pop_data.left_cnt;
      den[1] <= pop_data.right_cnt;
      for (int i = 0; i < 2; i++) begin
        rem[i] <= '0;
        quo[i] <= '0;
      end
    end else if (state == srhc_pkg::ST_DIV) begin
      for (int i = 0; i < 2; i++) begin
        num[i] <= {num[i][srhc_pkg::NUM_W-2:0], 1'b0};
        if (part[i] >= {1'b0, den[i]}) begin
          rem[i] <= diff[i][srhc_pkg::COUNT_W-1:0];
          quo[i] <= {quo[i][srhc_pkg::NUM_W-2:0], 1'b1};
        end else begin
          rem[i] <= part[i][srhc_pkg::COUNT_W-1:0];
          quo[i] <= {quo[i][srhc_pkg::NUM_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_both <= (den[0] != '0) && (den[1] != '0);
      for (int i = 0; i < 2; i++) begin
        out_cent[i] <= centroid(quo[i], den[i]);
        out_cnt[i]  <= den[i];
      end
    end
  end

  assign result.valid          = out_valid;
  assign result.both_found     = out_both;
  assign result.left_centroid  = out_cent[0];
  assign result.right_centroid = out_cent[1];
  assign result.left_count     = out_cnt[0];
  assign result.right_count    = out_cnt[1];

endmodule

### sv/stereo_red_hue_centroid_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_red_hue_centroid_top
// Red blob centroid of a stereo pair of scan lines.
//
// The pixel channel takes one left and one right RGB pixel per transfer,
// one transfer per cycle while the front pipeline runs; last_pixel closes
// the line pair. Each pixel is classed red by a pipelined hue test and
// its index is added to the per-eye count and sum. The line totals enter a
// two-entry queue; a bit-serial divider (one quotient bit per cycle)
// turns them into Q7.8 centroids, held in a result register.
// Line totals pass s1, s2, the queue and divider before result valid rises.
// The divider pops a line pair only when idle, so line pairs can outrun it:
// with the queue full, a further line end reaching s2 makes the pixel
// channel drop ready until an entry drains.
// A stalled result channel holds the result register; the divider and the
// queue keep working behind it until both fill.
// The hue window register is at APB byte address 0; the user must keep it
// written only while the block is idle, which the block does not enforce.
// Reset empties the pipeline, queue and result register, clears the line
// state and sets the window to 993 (a 10 degree half window).
// ----------------------------------------------------------------------------
module stereo_red_hue_centroid_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [srhc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [srhc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [srhc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  srhc_pixel_if.sink                        pixel,
  srhc_result_if.source                     result
);

  logic [srhc_pkg::WINDOW_W-1:0]  window;
  logic [srhc_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           push;
  logic                           pop;
  logic                           full;
  logic                           empty;
  srhc_pkg::line_tot_t            push_data;
  srhc_pkg::line_tot_t            pop_data;

  assign reg_idx = paddr[srhc_pkg::APB_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == srhc_pkg::REG_HUE_WINDOW) ?
                   srhc_pkg::APB_DATA_W'(window) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= srhc_pkg::WINDOW_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (reg_idx == srhc_pkg::REG_HUE_WINDOW)) begin
      window <= pwdata[srhc_pkg::WINDOW_W-1:0];
    end
  end

  srhc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pixel),
    .window    (window),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  srhc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  srhc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .pop_data (pop_data),
    .pop      (pop),
    .result   (result)
  );

endmodule
